// ----- sv/modexp_pkg.sv -----
// ============================================================================
// modexp_pkg: shared types and constants for the modular exponentiation unit
// Holds the prime modulus, the Barrett reduction constant, the command and
// status bundles between controller and datapath, and the product tag type.
// ============================================================================
`default_nettype none

package modexp_pkg;

    // Prime modulus and its multiples used by the reduction steps
    localparam logic [29:0] PRIME_MOD   = 30'd998244353;
    localparam logic [31:0] PRIME_MOD32 = 32'd998244353;
    localparam logic [31:0] PRIME_X2    = 32'd1996488706;

    // Barrett constant floor(2^60 / p), fits in 31 bits
    localparam logic [63:0] MU_FULL    = (64'd1 << 60) / 64'd998244353;
    localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture a new base and exponent
        logic issue_sq;   // start base * base
        logic issue_mul;  // start result * base
        logic shift_exp;  // advance to the next exponent bit
        logic out_load;   // copy the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic exp_bit;    // current exponent bit
    } t_dp_sts;

    // Tag that travels with a product through the reduction pipeline
    typedef struct packed {
        logic valid;
        logic to_res;     // write back to the result, else to the base
    } t_tag;

endpackage

`default_nettype wire

// ----- sv/modexp_dpath.sv -----
// ============================================================================
// modexp_dpath: square-and-multiply datapath
// Holds base, running result and exponent, one shared 30x30 multiplier and a
// four-stage Barrett reduction pipeline that writes back to base or result.
// ============================================================================
`default_nettype none

module modexp_dpath
    import modexp_pkg::*;
#(
    parameter int EXP_BITS = 63
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_sts          o_sts,
    input  wire logic [29:0] i_base_value,
    input  wire logic [62:0] i_exponent,
    output logic      [29:0] o_power_mod
);

    localparam int NBITS = (EXP_BITS < 63) ? EXP_BITS : 63;

    logic [29:0]      r_base;
    logic [29:0]      r_res;
    logic [NBITS-1:0] r_exp;
    logic [29:0]      r_out;

    logic [59:0] r_prod;
    logic [59:0] r_prod_d;
    logic [30:0] r_q;
    logic [31:0] r_rem;
    t_tag        r_tag1;
    t_tag        r_tag2;
    t_tag        r_tag3;

    logic [29:0] op_a;
    logic [59:0] mul_full;
    logic [61:0] q_full;
    logic [60:0] qp_full;
    logic [31:0] sub_p;
    logic [31:0] sub_2p;
    logic [29:0] wb_val;
    logic [29:0] base_red;

    // Select the left operand: base for squaring, result for multiplying
    assign op_a     = i_cmd.issue_mul ? r_res : r_base;
    assign mul_full = op_a * r_base;

    // Barrett quotient estimate and remainder
    assign q_full  = r_prod[59:29] * BARRETT_MU;
    assign qp_full = r_q * PRIME_MOD;

    // Final correction: remainder is below three times the prime
    assign sub_p  = r_rem - PRIME_MOD32;
    assign sub_2p = r_rem - PRIME_X2;
    always_comb begin
        if (r_rem >= PRIME_X2) begin
            wb_val = sub_2p[29:0];
        end else if (r_rem >= PRIME_MOD32) begin
            wb_val = sub_p[29:0];
        end else begin
            wb_val = r_rem[29:0];
        end
    end

    // Reduce the incoming base once; it is below twice the prime
    assign base_red = (i_base_value >= PRIME_MOD) ? (i_base_value - PRIME_MOD)
                                                  : i_base_value;

    // Track which products are in flight and where they go
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1.valid  <= i_cmd.issue_sq | i_cmd.issue_mul;
            r_tag1.to_res <= i_cmd.issue_mul;
            r_tag2        <= r_tag1;
            r_tag3        <= r_tag2;
        end
    end

    // Advance the multiply and reduction pipeline
    always_ff @(posedge i_clk) begin
        r_prod   <= mul_full;
        r_prod_d <= r_prod;
        r_q      <= q_full[61:31];
        r_rem    <= r_prod_d[31:0] - qp_full[31:0];
    end

    // Load operands, write back reduced products, shift the exponent
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base <= base_red;
            r_res  <= 30'd1;
            r_exp  <= i_exponent[NBITS-1:0];
        end else begin
            if (r_tag3.valid && !r_tag3.to_res) begin
                r_base <= wb_val;
            end
            if (r_tag3.valid && r_tag3.to_res) begin
                r_res <= wb_val;
            end
            if (i_cmd.shift_exp) begin
                r_exp <= r_exp >> 1;
            end
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    assign o_sts.exp_bit = r_exp[0];
    assign o_power_mod   = r_out;

    // Every write-back value is fully reduced
    a_wb_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag3.valid |-> (wb_val < PRIME_MOD))
        else $error("write-back value not reduced");

    // A started product moves on through the pipeline
    a_tag_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag1.valid |=> r_tag2.valid)
        else $error("product lost in reduction pipeline");

endmodule

`default_nettype wire

// ----- sv/modexp_ctrl.sv -----
// ============================================================================
// modexp_ctrl: sequencer for square-and-multiply
// Walks the exponent bits phase by phase, issues the square and the
// conditional multiply, drains the pipeline and hands off the result.
// ============================================================================
`default_nettype none

module modexp_ctrl
    import modexp_pkg::*;
#(
    parameter int EXP_BITS = 63
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    localparam int NBITS = (EXP_BITS < 63) ? EXP_BITS : 63;
    localparam int CNT_W = (NBITS > 1) ? $clog2(NBITS) : 1;
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(NBITS - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_FLUSH = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    localparam logic [1:0] PH_SQUARE = 2'd0;
    localparam logic [1:0] PH_MUL    = 2'd1;
    localparam logic [1:0] PH_NEXT   = 2'd3;

    t_state           r_state, n_state;
    logic [1:0]       r_phase, n_phase;
    logic [CNT_W-1:0] r_bit, n_bit;
    logic             r_out_valid, n_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_bit       = r_bit;
        n_out_valid = r_out_valid & i_stall;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                    n_phase    = PH_SQUARE;
                    n_bit      = '0;
                end
            end
            S_RUN: begin
                n_phase = r_phase + 2'd1;
                case (r_phase)
                    PH_SQUARE: o_cmd.issue_sq  = 1'b1;
                    PH_MUL:    o_cmd.issue_mul = i_sts.exp_bit;
                    PH_NEXT: begin
                        o_cmd.shift_exp = 1'b1;
                        if (r_bit == LAST_BIT) begin
                            n_state = S_FLUSH;
                        end else begin
                            n_bit = r_bit + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            S_FLUSH: begin
                // Last multiply writes back during this cycle
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_SQUARE;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

    // Square and multiply never share the multiplier in one cycle
    a_one_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.issue_sq && o_cmd.issue_mul))
        else $error("two products issued at once");

    // Output register is loaded only when free or being drained
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("output register overwritten");

    // Idle always restarts at the first phase
    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_phase == PH_SQUARE))
        else $error("phase counter not reset in idle");

    // A transfer in starts the bit loop
    a_load_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_RUN))
        else $error("load did not start the bit loop");

endmodule

`default_nettype wire

// ----- sv/modular_exponentiation_unit.sv -----
// ============================================================================
// modular_exponentiation_unit: base ^ exponent mod 998244353
// Right-to-left square-and-multiply over the low EXP_BITS exponent bits with
// a shared multiplier and Barrett reduction.
// ============================================================================
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  input   | in        | i_valid / o_stall  | i_base_value[29:0], i_exponent[62:0]
//  result  | out       | o_valid / i_stall  | o_power_mod[29:0]
//
//  Each exponent bit of an item goes through the four-stage multiply and
//  reduction loop between its transfer in and its result in the output
//  register. One item is worked at a time; o_stall is high from transfer in
//  until the result is loaded, and a result waiting under i_stall does not
//  block the next transfer in. Reset is synchronous, active low, and needs
//  no clearing.
//
`default_nettype none

module modular_exponentiation_unit
    import modexp_pkg::*;
#(
    parameter int EXP_BITS = 63
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [29:0] i_base_value,
    input  wire logic [62:0] i_exponent,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [29:0] o_power_mod
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer
    modexp_ctrl #(
        .EXP_BITS (EXP_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    // Arithmetic
    modexp_dpath #(
        .EXP_BITS (EXP_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_base_value (i_base_value),
        .i_exponent   (i_exponent),
        .o_power_mod  (o_power_mod)
    );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ============================================================================
// tb_top: self-checking testbench for modular_exponentiation_unit
// Drives base/exponent pairs through the valid/stall input channel, predicts
// base ^ exponent mod 998244353 by square-and-multiply, and checks every
// result transfer in order. A directed table covers the edge cases, then
// random bursts run against a receiver that stalls on its own pattern.
// ============================================================================

module tb_top;

    // Block configuration and run sizing
    localparam int          EXP_BITS     = 63;
    localparam logic [63:0] MODULUS      = 64'd998244353;
    localparam int          LATENCY      = 4 * EXP_BITS + 2;
    localparam int          NUM_DIRECTED = 20;
    localparam int          NUM_RANDOM   = 1230;
    localparam int          HOLD_AFTER   = 150;
    localparam int          HOLD_CYCLES  = 1200;
    localparam int          DRAIN_CYCLES = LATENCY + 50;
    localparam longint      RUN_LIMIT    = 64'd16_000_000;

    localparam logic [29:0] BASE_MAX = 30'h3FFF_FFFF;
    localparam logic [62:0] EXP_MAX  = {63{1'b1}};
    localparam logic [29:0] PRIME    = 30'd998244353;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SPARSE,
        STALL_DENSE,
        STALL_PERIODIC
    } t_stall_mode;

    // One directed row: operands, and the answer where it is known outright
    typedef struct packed {
        logic [29:0] base;
        logic [62:0] expo;
        logic        known;
        logic [29:0] power;
    } t_power_case;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [29:0] i_base_value;
    logic [62:0] i_exponent;
    logic        o_valid;
    logic        i_stall;
    logic [29:0] o_power_mod;

    logic [29:0] pending_powers [$];
    logic [29:0] oldest_power;
    t_power_case directed_cases [NUM_DIRECTED];
    int          results_seen = 0;
    int          failures     = 0;
    int          items_sent   = 0;

    modular_exponentiation_unit #(
        .EXP_BITS (EXP_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_base_value (i_base_value),
        .i_exponent   (i_exponent),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_power_mod  (o_power_mod)
    );

    // Clock: period 8
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Right-to-left square-and-multiply over the low exponent bits
    function automatic logic [29:0] modpow_expected(input logic [29:0] base,
                                                    input logic [62:0] expo);
        logic [63:0] acc;
        logic [63:0] sq;
        int          nbits;
        nbits = (EXP_BITS < 63) ? EXP_BITS : 63;
        acc   = 64'd1;
        sq    = {34'd0, base} % MODULUS;
        for (int k = 0; k < nbits; k++) begin
            if (expo[k]) begin
                acc = (acc * sq) % MODULUS;
            end
            sq = (sq * sq) % MODULUS;
        end
        return acc[29:0];
    endfunction

    // Offer one item and hold it until the transfer, then log its answer
    task automatic send_power(input logic [29:0] base, input logic [62:0] expo,
                              input logic known, input logic [29:0] power);
        @(negedge i_clk);
        i_valid      = 1'b1;
        i_base_value = base;
        i_exponent   = expo;
        do @(posedge i_clk); while (o_stall);
        pending_powers.push_back(known ? power : modpow_expected(base, expo));
        items_sent++;
    endtask

    // Drop valid for a number of cycles, with junk on the payload
    task automatic idle_sender(input int cycles);
        @(negedge i_clk);
        i_valid      = 1'b0;
        i_base_value = 30'($urandom());
        i_exponent   = {31'($urandom()), 32'($urandom())};
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Drop valid until every outstanding power has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_powers.size() != 0) @(negedge i_clk);
    endtask

    // Random base, weighted toward zero, small values, the prime's neighborhood and values above it
    function automatic logic [29:0] random_base();
        case ($urandom_range(0, 7))
            4:       return 30'($urandom_range(0, 15));
            5:       return PRIME - 30'd8 + 30'($urandom_range(0, 16));
            6:       return 30'($urandom_range(32'(PRIME), 32'(BASE_MAX)));
            7:       return ($urandom_range(0, 1) == 0) ? 30'd0 : PRIME;
            default: return 30'($urandom());
        endcase
    endfunction

    // Random exponent of random bit length, with zero and all ones now and then
    function automatic logic [62:0] random_exponent();
        logic [62:0] raw;
        int          width;
        raw   = {31'($urandom()), 32'($urandom())};
        width = $urandom_range(1, 63);
        case ($urandom_range(0, 15))
            0:       return 63'd0;
            1:       return EXP_MAX;
            default: return raw & ((63'd1 << width) - 63'd1);
        endcase
    endfunction

    // Stimulus: reset, directed table, random bursts, final drain
    initial begin : stimulus
        int sent;
        int burst;
        int gap;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_base_value = 30'd0;
        i_exponent   = 63'd0;
        directed_cases = '{
            {30'd0,             63'd0,                     1'b1, 30'd1},
            {BASE_MAX,          63'd0,                     1'b1, 30'd1},
            {PRIME,             63'd0,                     1'b1, 30'd1},
            {PRIME,             63'd5,                     1'b1, 30'd0},
            {30'd0,             63'd1,                     1'b1, 30'd0},
            {30'd0,             EXP_MAX,                   1'b1, 30'd0},
            {30'd1,             EXP_MAX,                   1'b1, 30'd1},
            {30'd2,             63'd1,                     1'b1, 30'd2},
            {30'd2,             63'd10,                    1'b1, 30'd1024},
            {PRIME + 30'd2,     63'd10,                    1'b1, 30'd1024},
            {PRIME - 30'd1,     63'd2,                     1'b1, 30'd1},
            {PRIME - 30'd1,     63'd3,                     1'b1, PRIME - 30'd1},
            {30'd3,             63'd998244352,             1'b1, 30'd1},
            {30'd536870912,     63'd1,                     1'b1, 30'd536870912},
            {BASE_MAX,          63'd1,                     1'b1, 30'd75497470},
            {BASE_MAX,          EXP_MAX,                   1'b0, 30'd0},
            {30'd12345,         63'd1 << 62,               1'b0, 30'd0},
            {{15{2'b10}},       {{31{2'b10}}, 1'b1},       1'b0, 30'd0},
            {{15{2'b01}},       {{31{2'b01}}, 1'b0},       1'b0, 30'd0},
            {30'd7,             63'd123456789,             1'b0, 30'd0}
        };
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table back to back
        for (int row = 0; row < NUM_DIRECTED; row++) begin
            send_power(directed_cases[row].base, directed_cases[row].expo,
                       directed_cases[row].known, directed_cases[row].power);
        end

        // Random bursts with random gaps; pause once midway for a full drain
        sent = 0;
        while (sent < NUM_RANDOM) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < NUM_RANDOM; k++) begin
                send_power(random_base(), random_exponent(), 1'b0, 30'd0);
                sent++;
                if (sent == NUM_RANDOM / 2) begin
                    drain_results();
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                idle_sender(gap);
            end
        end

        // Wait out every result, then the block's latency
        drain_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_powers.size() != 0) begin
            $error("power_mod: %0d results never arrived", pending_powers.size());
            failures++;
        end

        $display("Sent %0d directed and %0d random base/exponent pairs, %0d powers checked",
                 NUM_DIRECTED, sent, results_seen);
        $display("Receiver held off %0d cycles once; %0d mismatches seen",
                 HOLD_CYCLES, failures);
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Receiver: switch stall pattern now and then, and hold off once for a long stretch
    initial begin : result_sink
        t_stall_mode mode;
        int          cyc;
        bit          held;
        i_stall = 1'b0;
        mode    = STALL_NONE;
        cyc     = 0;
        held    = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (!held && results_seen >= HOLD_AFTER) begin
                held    = 1'b1;
                i_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (cyc % 101 == 0) begin
                mode = t_stall_mode'($urandom_range(0, 3));
            end
            case (mode)
                STALL_NONE:   i_stall = 1'b0;
                STALL_SPARSE: i_stall = ($urandom_range(0, 7) == 0);
                STALL_DENSE:  i_stall = ($urandom_range(0, 1) == 0);
                default:      i_stall = (cyc % 3 != 0);
            endcase
        end
    end

    // Check each result transfer against the oldest outstanding power
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_powers.size() == 0) begin
                $error("power_mod: unexpected result, actual %0d", o_power_mod);
                failures++;
            end else begin
                oldest_power = pending_powers.pop_front();
                if (o_power_mod !== oldest_power) begin
                    $error("power_mod: expected %0d, actual %0d",
                           oldest_power, o_power_mod);
                    failures++;
                end
            end
        end
    end

    // Stop a hung run
    initial begin : run_limit
        #(RUN_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/modexp_pkg.sv
sv/modexp_dpath.sv
sv/modexp_ctrl.sv
sv/modular_exponentiation_unit.sv
tb/tb_top.sv
